### hdl/swmm_pkg.sv
`default_nettype none
package swmm_pkg;

  localparam int unsigned SampleW   = 32;
  localparam int unsigned WindowMax = 64;
  localparam int unsigned CountW    = $clog2(WindowMax + 1);

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      restart;
  } in_beat_t;

  typedef struct packed {
    logic signed [SampleW-1:0] window_min;
    logic signed [SampleW-1:0] window_max;
  } out_beat_t;

  typedef struct packed {
    logic signed [SampleW-1:0] value;
    logic                      min_live;
    logic                      max_live;
  } cell_data_t;

  typedef struct packed {
    logic shift;
    logic flush;
    logic cmp_en;
    logic in_win;
  } cell_ctrl_t;

endpackage
`default_nettype wire

### hdl/swmm_cell.sv
`default_nettype none
module swmm_cell (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire swmm_pkg::cell_ctrl_t                  ctrl_i,
  input  wire logic signed [swmm_pkg::SampleW-1:0]   sample_i,
  input  wire swmm_pkg::cell_data_t                  left_i,
  output swmm_pkg::cell_data_t                       cell_o
);

  logic signed [swmm_pkg::SampleW-1:0] value_q;
  logic                                min_live_q, min_live_d;
  logic                                max_live_q, max_live_d;
  logic                                keep;

  // an entry survives a shift if in the window, unflushed and not dominated by the new sample
  assign keep       = ctrl_i.in_win & ~ctrl_i.flush;
  assign min_live_d = left_i.min_live & keep & ~(ctrl_i.cmp_en & (left_i.value >= sample_i));
  assign max_live_d = left_i.max_live & keep & ~(ctrl_i.cmp_en & (left_i.value <= sample_i));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      value_q <= left_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_live_q <= 1'b0;
      max_live_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      min_live_q <= min_live_d;
      max_live_q <= max_live_d;
    end
  end

  assign cell_o.value    = value_q;
  assign cell_o.min_live = min_live_q;
  assign cell_o.max_live = max_live_q;

endmodule
`default_nettype wire

### hdl/swmm_front.sv
`default_nettype none
module swmm_front (
  input  wire logic [swmm_pkg::WindowMax-1:0]                        live_i,
  input  wire logic [swmm_pkg::WindowMax-1:0][swmm_pkg::SampleW-1:0] values_i,
  output logic signed [swmm_pkg::SampleW-1:0]                        pick_o
);

  logic [swmm_pkg::WindowMax-1:0] rev;
  logic [swmm_pkg::WindowMax-1:0] rev_oh;
  logic [swmm_pkg::WindowMax-1:0] sel;
  logic [swmm_pkg::SampleW-1:0]   acc;

  // oldest live entry is the queue front: highest set index
  always_comb begin
    for (int k = 0; k < swmm_pkg::WindowMax; k++) begin
      rev[k] = live_i[swmm_pkg::WindowMax-1-k];
    end
    rev_oh = rev & (~rev + {{(swmm_pkg::WindowMax-1){1'b0}}, 1'b1});
    for (int k = 0; k < swmm_pkg::WindowMax; k++) begin
      sel[k] = rev_oh[swmm_pkg::WindowMax-1-k];
    end
    acc = '0;
    for (int k = 0; k < swmm_pkg::WindowMax; k++) begin
      acc = acc | (values_i[k] & {swmm_pkg::SampleW{sel[k]}});
    end
  end

  assign pick_o = $signed(acc);

endmodule
`default_nettype wire

### hdl/sliding_window_min_max_top.sv
// Sliding window minimum and maximum over a stream of signed samples.
// Input channel: in_valid_i / in_stall_o carry one sample and a restart flag
// per beat; restart empties the window so the sample opens a new stream.
// Output channel: out_valid_o / out_stall_i carry the window minimum and
// maximum together, one beat per sample once window_size samples have been
// seen since the last restart; warm-up samples give no beat.
// Configuration: cfg_valid_i / cfg_ready_o write window_size (0 acts as 1,
// above 64 acts as 64); ready is always high; write only while idle.
// One sample per cycle is sustained while the receiver does not stall:
// each sample shifts a row of 64 cells by one place and every cell
// but the first compares against the new sample in parallel; the queue
// fronts are then picked from the row into the output register.
// When the receiver stalls, the output register holds its beat and one
// further result may wait in the row; beyond that in_stall_o is raised.
// Reset clears the window, the sample count and sets window_size to 1.
`default_nettype none
module sliding_window_min_max_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [swmm_pkg::CountW-1:0]    cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire swmm_pkg::in_beat_t             in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output swmm_pkg::out_beat_t                 out_data_o
);

  localparam int unsigned N  = swmm_pkg::WindowMax;
  localparam int unsigned CW = swmm_pkg::CountW;

  logic [CW-1:0] win_q;
  logic [CW-1:0] eff_w;
  logic [CW-1:0] seen_q, seen_d, seen_base;
  logic          pend_q, pend_d;
  logic          accept, emit, load;
  logic          out_valid_q;
  swmm_pkg::out_beat_t out_q;

  swmm_pkg::cell_data_t [N-1:0] row;
  swmm_pkg::cell_data_t         head;
  logic [N-1:0]                 min_live, max_live;
  logic [N-1:0][swmm_pkg::SampleW-1:0] values;
  logic signed [swmm_pkg::SampleW-1:0] min_pick, max_pick;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= CW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      win_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (win_q == '0) begin
      eff_w = CW'(1);
    end else if (win_q > CW'(N)) begin
      eff_w = CW'(N);
    end else begin
      eff_w = win_q;
    end
  end

  assign load       = pend_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = pend_q && !load;
  assign accept     = in_valid_i && !in_stall_o;

  assign seen_base = in_data_i.restart ? '0 : seen_q;
  assign seen_d    = (seen_base < eff_w) ? seen_base + CW'(1) : eff_w;
  assign emit      = (seen_d == eff_w);
  assign pend_d    = (accept && emit) ? 1'b1 : (load ? 1'b0 : pend_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      pend_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      if (accept) begin
        seen_q <= seen_d;
      end
    end
  end

  assign head.value    = in_data_i.sample;
  assign head.min_live = 1'b1;
  assign head.max_live = 1'b1;

  for (genvar k = 0; k < N; k++) begin : g_cell
    swmm_pkg::cell_ctrl_t ctrl;
    swmm_pkg::cell_data_t left;
    if (k == 0) begin : g_head
      assign left        = head;
      assign ctrl.flush  = 1'b0;
      assign ctrl.cmp_en = 1'b0;
    end else begin : g_body
      assign left        = row[k-1];
      assign ctrl.flush  = in_data_i.restart;
      assign ctrl.cmp_en = 1'b1;
    end
    assign ctrl.shift  = accept;
    assign ctrl.in_win = (CW'(k) < eff_w);

    swmm_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .sample_i (in_data_i.sample),
      .left_i   (left),
      .cell_o   (row[k])
    );

    assign min_live[k] = row[k].min_live;
    assign max_live[k] = row[k].max_live;
    assign values[k]   = row[k].value;
  end

  swmm_front u_min_front (
    .live_i   (min_live),
    .values_i (values),
    .pick_o   (min_pick)
  );

  swmm_front u_max_front (
    .live_i   (max_live),
    .values_i (values),
    .pick_o   (max_pick)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.window_min <= min_pick;
      out_q.window_max <= max_pick;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.window_min <= out_data_o.window_max))
    else $error("window minimum above maximum");

  a_head_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (min_live[0] && max_live[0]))
    else $error("newest sample missing from a queue");

  a_pend_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> ((|min_live) && (|max_live)))
    else $error("result pending on an empty queue");

  a_pend_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && !load) |=> (pend_q && $stable(min_live) && $stable(max_live)))
    else $error("pending result lost while output stalled");

endmodule
`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  localparam int MinSide = 0;
  localparam int MaxSide = 1;

  typedef logic [swmm_pkg::CountW-1:0] win_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  win_t                    cfg_data_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  swmm_pkg::in_beat_t      in_data_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  swmm_pkg::out_beat_t     out_data_o;

  // Predictor state: one monotone deque per side, values and ages
  logic signed [swmm_pkg::SampleW-1:0] mono_val [2][swmm_pkg::WindowMax];
  int unsigned               mono_age [2][swmm_pkg::WindowMax];
  int unsigned               mono_cnt [2];
  int unsigned               seen_cnt;
  win_t                      window_reg;
  swmm_pkg::out_beat_t       minmax_q[$];
  int unsigned               err_cnt;
  int unsigned               idle_pct;
  int unsigned               stall_pct;

  sliding_window_min_max_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned span_of(win_t r);
    if (r == '0) return 1;
    if (r > swmm_pkg::WindowMax) return swmm_pkg::WindowMax;
    return 32'(r);
  endfunction

  function automatic void mono_push(int side, logic signed [swmm_pkg::SampleW-1:0] v,
                                    int unsigned span);
    int unsigned drop;
    bit          pop;
    drop = 0;
    for (int unsigned i = 0; i < mono_cnt[side]; i++) begin
      if (mono_age[side][i] < swmm_pkg::WindowMax) mono_age[side][i]++;
    end
    while (drop < mono_cnt[side] && mono_age[side][drop] >= span) drop++;
    for (int unsigned i = 0; i + drop < mono_cnt[side]; i++) begin
      mono_val[side][i] = mono_val[side][i+drop];
      mono_age[side][i] = mono_age[side][i+drop];
    end
    mono_cnt[side] -= drop;
    while (mono_cnt[side] > 0) begin
      if (side == MinSide) pop = mono_val[side][mono_cnt[side]-1] >= v;
      else pop = mono_val[side][mono_cnt[side]-1] <= v;
      if (!pop) break;
      mono_cnt[side]--;
    end
    if (mono_cnt[side] < swmm_pkg::WindowMax) begin
      mono_val[side][mono_cnt[side]] = v;
      mono_age[side][mono_cnt[side]] = 0;
      mono_cnt[side]++;
    end
  endfunction

  function automatic void predict_window(swmm_pkg::in_beat_t b);
    int unsigned         span;
    swmm_pkg::out_beat_t r;
    span = span_of(window_reg);
    if (b.restart) begin
      mono_cnt[MinSide] = 0;
      mono_cnt[MaxSide] = 0;
      seen_cnt = 0;
    end
    mono_push(MinSide, b.sample, span);
    mono_push(MaxSide, b.sample, span);
    if (seen_cnt < span) seen_cnt++;
    if (seen_cnt > span) seen_cnt = span;
    if (seen_cnt == span) begin
      r.window_min = mono_val[MinSide][0];
      r.window_max = mono_val[MaxSide][0];
      minmax_q.push_back(r);
    end
  endfunction

  function automatic void check_result(swmm_pkg::out_beat_t got);
    swmm_pkg::out_beat_t want;
    if (minmax_q.size() == 0) begin
      $error("unexpected result beat: min %0d max %0d", got.window_min, got.window_max);
      err_cnt++;
      return;
    end
    want = minmax_q.pop_front();
    if (got.window_min !== want.window_min) begin
      $error("window_min: expected %0d, got %0d", want.window_min, got.window_min);
      err_cnt++;
    end
    if (got.window_max !== want.window_max) begin
      $error("window_max: expected %0d, got %0d", want.window_max, got.window_max);
      err_cnt++;
    end
  endfunction

  // Output checked before the input beat of the same edge is predicted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) check_result(out_data_o);
      if (in_valid_i && !in_stall_o) predict_window(in_data_i);
      if (cfg_valid_i && cfg_ready_o) window_reg = cfg_data_i;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  function automatic logic signed [swmm_pkg::SampleW-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return {1'b0, {(swmm_pkg::SampleW-1){1'b1}}};
      1:       return {1'b1, {(swmm_pkg::SampleW-1){1'b0}}};
      2, 3, 4: return $signed($urandom_range(0, 7)) - 4;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_sample(logic signed [swmm_pkg::SampleW-1:0] s, logic r);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{sample: s, restart: r};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic settle_window();
    int unsigned guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (minmax_q.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    if (minmax_q.size() != 0) begin
      $error("%0d expected result beats never arrived", minmax_q.size());
      err_cnt++;
      minmax_q.delete();
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_window(win_t w);
    settle_window();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= w;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_extremes();
    write_window(win_t'(1));
    send_sample(32'sh7FFFFFFF, 1'b0);
    send_sample(32'sh80000000, 1'b0);
    send_sample(0, 1'b1);
    send_sample(-1, 1'b0);
    send_sample(32'sh55555555, 1'b0);
    send_sample(32'shAAAAAAAA, 1'b1);
  endtask

  task automatic test_ties_and_restart();
    write_window(win_t'(3));
    send_sample(7, 1'b0);
    send_sample(7, 1'b0);
    send_sample(7, 1'b0);
    send_sample(2, 1'b0);
    send_sample(9, 1'b0);
    send_sample(9, 1'b0);
    send_sample(-5, 1'b1);
    send_sample(4, 1'b0);
  endtask

  task automatic test_zero_window();
    write_window(win_t'(0));
    send_sample(3, 1'b1);
    send_sample(-3, 1'b0);
    send_sample(1, 1'b0);
  endtask

  // rising run at 5, then shrink to 2 so several aged fronts go at once
  task automatic test_window_shrink();
    write_window(win_t'(5));
    for (int i = 1; i <= 5; i++) send_sample(i, i == 1);
    write_window(win_t'(2));
    send_sample(6, 1'b0);
    send_sample(7, 1'b0);
  endtask

  task automatic test_random_stream(int n, win_t w, int unsigned idle,
                                    int unsigned stall, int unsigned restart_pct);
    write_window(w);
    idle_pct  = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      send_sample(rand_sample(), $urandom_range(0, 99) < restart_pct);
    end
  endtask

  task automatic test_pause_resume();
    write_window(win_t'(6));
    idle_pct  = 14;
    stall_pct = 14;
    for (int i = 0; i < 20; i++) send_sample(rand_sample(), 1'b0);
    settle_window();
    for (int i = 0; i < 20; i++) send_sample(rand_sample(), 1'b0);
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    idle_pct    = 0;
    stall_pct   = 0;
    err_cnt     = 0;
    seen_cnt    = 0;
    window_reg  = win_t'(1);
    mono_cnt[MinSide] = 0;
    mono_cnt[MaxSide] = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_extremes();
    test_ties_and_restart();
    test_zero_window();
    test_window_shrink();
    test_random_stream(150, win_t'(64), 0, 0, 0);
    test_random_stream(100, win_t'(4), 0, 0, 2);
    test_random_stream(150, win_t'($urandom_range(1, 16)), 78, 0, 3);
    test_random_stream(50, win_t'(0), 78, 0, 3);
    test_random_stream(150, win_t'($urandom_range(1, 63)), 0, 78, 1);
    test_random_stream(150, win_t'(127), 0, 78, 0);
    test_random_stream(200, win_t'($urandom_range(2, 8)), 14, 14, 3);
    test_random_stream(50, win_t'(1), 14, 14, 5);
    test_random_stream(150, win_t'($urandom_range(0, 127)), 14, 14, 1);
    test_pause_resume();

    stall_pct = 0;
    settle_window();
    repeat (6) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
